// ===== hdl/multidim_array_address_generator_top_assert.svh =====
// Assertion macros shared by the address generator modules.
// Each use names a label and the expressions; clk and rst_n must be in scope.
`ifndef MULTIDIM_ARRAY_ADDRESS_GENERATOR_TOP_ASSERT_SVH
`define MULTIDIM_ARRAY_ADDRESS_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define MADG_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("madg assertion failed");

`define MADG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("madg assertion failed");

`define MADG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("madg assertion failed");

`else

`define MADG_ASSERT_ALWAYS(lbl, cond)
`define MADG_ASSERT_IMPL(lbl, ante, cons)
`define MADG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/madg_pkg.sv =====
`timescale 1ns / 1ps

package madg_pkg;

    // Table geometry
    localparam int MAX_ARRAYS = 16;
    localparam int MAX_DIMS   = 10;
    localparam int TAB_DEPTH  = MAX_ARRAYS * MAX_DIMS;
    localparam int TAB_AW     = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
    localparam int DIM_W      = $clog2(MAX_DIMS + 1);
    localparam int DESC_W     = 32 + DIM_W;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_BOUNDS = 2'd0,
        OP_DEFINE = 2'd1,
        OP_INDEX  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BOUNDS,
        ST_DEF_RD,
        ST_DEF_MUL,
        ST_DEF_ACC,
        ST_REF_RD,
        ST_REF_MUL,
        ST_REF_ACC
    } state_t;

    // One classified item waiting for the back end
    typedef struct packed {
        op_t                op;
        logic               id_ok;
        logic [3:0]         id;
        logic [TAB_AW-1:0]  row;
        logic [3:0]         dim;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic [30:0]        base;
        logic [15:0]        size;
        logic [DIM_W-1:0]   cnt;
        logic signed [15:0] index;
        logic               last;
    } q_entry_t;

endpackage

// ===== hdl/madg_if.sv =====
`timescale 1ns / 1ps

interface madg_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [3:0]         array_id;
    logic [3:0]         dim_index;
    logic signed [15:0] lower_bound;
    logic signed [15:0] upper_bound;
    logic [30:0]        base_address;
    logic [15:0]        element_size;
    logic [3:0]         dimension_count;
    logic signed [15:0] index_value;
    logic               last;

    modport source (
        output valid, op, array_id, dim_index, lower_bound, upper_bound,
               base_address, element_size, dimension_count, index_value, last,
        input  ready
    );
    modport sink (
        input  valid, op, array_id, dim_index, lower_bound, upper_bound,
               base_address, element_size, dimension_count, index_value, last,
        output ready
    );
endinterface

interface madg_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         ref_array_id;
    logic signed [31:0] address;

    modport source (output valid, ref_array_id, address, input ready);
    modport sink (input valid, ref_array_id, address, output ready);
endinterface

// ===== hdl/multidim_array_address_generator_top.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload
// items     in   op, array_id, dim_index, bounds, base, size, count, index, last
// results   out  ref_array_id, address (one beat per reference, on its last index)
//
// Bounds items pass IDLE and BOUNDS, index items IDLE, REF_RD, REF_MUL, REF_ACC;
// a define runs DEF_RD, DEF_MUL, DEF_ACC per dimension; table reads are registered.
// A two-entry queue takes beats while the back end works; a full queue drops ready.
// Reset clears control only; tables hold nothing until written, with no clearing pass.
// A waiting result is held in the output register and stalls only the next emit.

module multidim_array_address_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    madg_in_if.sink     items,
    madg_out_if.source  results
);

    madg_pkg::q_entry_t q_head;
    logic               q_valid;
    logic               q_pop;

    madg_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .q_head  (q_head),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    madg_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .results (results)
    );

endmodule

// ===== hdl/madg_ram.sv =====
`timescale 1ns / 1ps

module madg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word with a registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/madg_front.sv =====
`timescale 1ns / 1ps
`include "multidim_array_address_generator_top_assert.svh"

module madg_front (
    input  logic                clk,
    input  logic                rst_n,
    madg_in_if.sink             items,
    output madg_pkg::q_entry_t  q_head,
    output logic                q_valid,
    input  logic                q_pop
);

    madg_pkg::q_entry_t             q_mem_reg [madg_pkg::QDEPTH];
    logic [madg_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [madg_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [madg_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [madg_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [madg_pkg::QCNT_W-1:0]    count_reg;
    logic [madg_pkg::QCNT_W-1:0]    count_next;
    madg_pkg::q_entry_t             entry;
    logic                           id_ok;
    logic                           keep;
    logic                           push;

    // Classify the incoming beat
    always_comb
    begin
        id_ok       = int'(items.array_id) < madg_pkg::MAX_ARRAYS;
        entry.op    = madg_pkg::op_t'(items.op);
        entry.id_ok = id_ok;
        entry.id    = items.array_id;
        entry.row   = madg_pkg::TAB_AW'(int'(items.array_id) * madg_pkg::MAX_DIMS);
        entry.dim   = items.dim_index;
        entry.lo    = items.lower_bound;
        entry.hi    = items.upper_bound;
        entry.base  = items.base_address;
        entry.size  = items.element_size;
        entry.index = items.index_value;
        entry.last  = items.last;
        // clamp dimension count into 1..MAX_DIMS
        if (items.dimension_count == 4'd0)
        begin
            entry.cnt = madg_pkg::DIM_W'(1);
        end
        else if (int'(items.dimension_count) > madg_pkg::MAX_DIMS)
        begin
            entry.cnt = madg_pkg::DIM_W'(madg_pkg::MAX_DIMS);
        end
        else
        begin
            entry.cnt = madg_pkg::DIM_W'(items.dimension_count);
        end

        // drop items that change nothing
        case (entry.op)
            madg_pkg::OP_BOUNDS: keep = id_ok && (int'(items.dim_index) < madg_pkg::MAX_DIMS);
            madg_pkg::OP_DEFINE: keep = id_ok;
            madg_pkg::OP_INDEX:  keep = 1'b1;
            default:             keep = 1'b0;
        endcase
    end

    assign items.ready = (count_reg != madg_pkg::QCNT_W'(madg_pkg::QDEPTH));
    assign push        = items.valid && items.ready && keep;
    assign q_valid     = (count_reg != '0);
    assign q_head      = q_mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == madg_pkg::QPTR_W'(madg_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == madg_pkg::QPTR_W'(madg_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store queue entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

    `MADG_ASSERT_ALWAYS(a_q_count_bound, count_reg <= madg_pkg::QCNT_W'(madg_pkg::QDEPTH))
    `MADG_ASSERT_IMPL(a_q_pop_nonempty, q_pop, count_reg != '0)

endmodule

// ===== hdl/madg_back.sv =====
`timescale 1ns / 1ps
`include "multidim_array_address_generator_top_assert.svh"

module madg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  madg_pkg::q_entry_t  q_head,
    input  logic                q_valid,
    output logic                q_pop,
    madg_out_if.source          results
);

    madg_pkg::state_t               state_reg;
    madg_pkg::state_t               state_next;
    madg_pkg::q_entry_t             cur_reg;
    madg_pkg::q_entry_t             cur_next;
    logic [madg_pkg::DIM_W-1:0]     k_reg;
    logic [madg_pkg::DIM_W-1:0]     k_next;
    logic [madg_pkg::DIM_W-1:0]     pos_reg;
    logic [madg_pkg::DIM_W-1:0]     pos_next;
    logic [31:0]                    coef_reg;
    logic [31:0]                    coef_next;
    logic [31:0]                    c0_reg;
    logic [31:0]                    c0_next;
    logic [31:0]                    prod_reg;
    logic [31:0]                    prod_next;
    logic [31:0]                    span_reg;
    logic [31:0]                    span_next;
    logic [31:0]                    offs_reg;
    logic [31:0]                    offs_next;
    logic                           hit_reg;
    logic                           hit_next;
    logic [31:0]                    acc_reg;
    logic [31:0]                    acc_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [3:0]                     out_id_reg;
    logic [3:0]                     out_id_next;
    logic [31:0]                    out_addr_reg;
    logic [31:0]                    out_addr_next;

    // Memory ports
    logic                           bnd_we;
    logic [madg_pkg::TAB_AW-1:0]    bnd_waddr;
    logic [madg_pkg::TAB_AW-1:0]    bnd_raddr;
    logic [31:0]                    bnd_rdata;
    logic                           coef_we;
    logic [madg_pkg::TAB_AW-1:0]    coef_waddr;
    logic [madg_pkg::TAB_AW-1:0]    coef_raddr;
    logic [31:0]                    coef_rdata;
    logic                           desc_we;
    logic [3:0]                     desc_addr;
    logic [madg_pkg::DESC_W-1:0]    desc_wdata;
    logic [madg_pkg::DESC_W-1:0]    desc_rdata;

    logic                           out_busy;
    logic                           out_load;
    logic [31:0]                    lo_ext;
    logic [31:0]                    hi_ext;
    logic [31:0]                    idx_ext;
    logic [31:0]                    acc_sum;
    logic [madg_pkg::DIM_W-1:0]     desc_dims;

    // Bounds table: upper in the high half, lower in the low half
    madg_ram #(.WIDTH(32), .DEPTH(madg_pkg::TAB_DEPTH)) u_bnd_ram (
        .clk   (clk),
        .we    (bnd_we),
        .waddr (bnd_waddr),
        .wdata ({cur_reg.hi, cur_reg.lo}),
        .raddr (bnd_raddr),
        .rdata (bnd_rdata)
    );

    madg_ram #(.WIDTH(32), .DEPTH(madg_pkg::TAB_DEPTH)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_reg),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // Descriptor table: dimension count over constant offset
    madg_ram #(.WIDTH(madg_pkg::DESC_W), .DEPTH(madg_pkg::MAX_ARRAYS)) u_desc_ram (
        .clk   (clk),
        .we    (desc_we),
        .waddr (desc_addr[((madg_pkg::MAX_ARRAYS > 1) ? $clog2(madg_pkg::MAX_ARRAYS) : 1)-1:0]),
        .wdata (desc_wdata),
        .raddr (desc_addr[((madg_pkg::MAX_ARRAYS > 1) ? $clog2(madg_pkg::MAX_ARRAYS) : 1)-1:0]),
        .rdata (desc_rdata)
    );

    assign out_busy  = out_valid_reg && !results.ready;
    assign lo_ext    = {{16{bnd_rdata[15]}}, bnd_rdata[15:0]};
    assign hi_ext    = {{16{bnd_rdata[31]}}, bnd_rdata[31:16]};
    assign idx_ext   = {{16{cur_reg.index[15]}}, cur_reg.index};
    assign acc_sum   = acc_reg + (hit_reg ? prod_reg : 32'd0);
    assign desc_dims = desc_rdata[madg_pkg::DESC_W-1:32];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            madg_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_head.op)
                        madg_pkg::OP_BOUNDS: state_next = madg_pkg::ST_BOUNDS;
                        madg_pkg::OP_DEFINE: state_next = madg_pkg::ST_DEF_RD;
                        madg_pkg::OP_INDEX:  state_next = madg_pkg::ST_REF_RD;
                        default:             state_next = madg_pkg::ST_IDLE;
                    endcase
                end
            end
            madg_pkg::ST_BOUNDS:  state_next = madg_pkg::ST_IDLE;
            madg_pkg::ST_DEF_RD:  state_next = madg_pkg::ST_DEF_MUL;
            madg_pkg::ST_DEF_MUL: state_next = madg_pkg::ST_DEF_ACC;
            madg_pkg::ST_DEF_ACC:
            begin
                state_next = (k_reg == '0) ? madg_pkg::ST_IDLE : madg_pkg::ST_DEF_RD;
            end
            madg_pkg::ST_REF_RD:  state_next = madg_pkg::ST_REF_MUL;
            madg_pkg::ST_REF_MUL: state_next = madg_pkg::ST_REF_ACC;
            madg_pkg::ST_REF_ACC:
            begin
                if (!(cur_reg.last && out_busy))
                begin
                    state_next = madg_pkg::ST_IDLE;
                end
            end
            default:              state_next = madg_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        q_pop      = 1'b0;
        bnd_we     = 1'b0;
        coef_we    = 1'b0;
        desc_we    = 1'b0;
        out_load   = 1'b0;
        bnd_waddr  = madg_pkg::TAB_AW'(int'(cur_reg.row) + int'(cur_reg.dim));
        bnd_raddr  = madg_pkg::TAB_AW'(int'(cur_reg.row) + int'(k_reg));
        coef_waddr = madg_pkg::TAB_AW'(int'(cur_reg.row) + int'(k_reg));
        coef_raddr = madg_pkg::TAB_AW'(int'(cur_reg.row) + int'(pos_reg));
        desc_addr  = cur_reg.id;
        desc_wdata = {cur_reg.cnt, c0_reg - prod_reg};
        case (state_reg)
            madg_pkg::ST_IDLE:    q_pop    = q_valid;
            madg_pkg::ST_BOUNDS:  bnd_we   = 1'b1;
            madg_pkg::ST_DEF_MUL: coef_we  = 1'b1;
            madg_pkg::ST_DEF_ACC: desc_we  = (k_reg == '0);
            madg_pkg::ST_REF_ACC: out_load = cur_reg.last && !out_busy;
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Datapath
    always_comb
    begin
        cur_next       = cur_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        coef_next      = coef_reg;
        c0_next        = c0_reg;
        prod_next      = prod_reg;
        span_next      = span_reg;
        offs_next      = offs_reg;
        hit_next       = hit_reg;
        acc_next       = acc_reg;
        out_id_next    = out_id_reg;
        out_addr_next  = out_addr_reg;
        out_valid_next = out_valid_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            madg_pkg::ST_IDLE:
            begin
                // load the head item and seed the dimension walk
                if (q_valid)
                begin
                    cur_next  = q_head;
                    k_next    = madg_pkg::DIM_W'(q_head.cnt - 1'b1);
                    coef_next = {16'd0, q_head.size};
                    c0_next   = {1'b0, q_head.base};
                end
            end
            madg_pkg::ST_DEF_MUL:
            begin
                prod_next = coef_reg * lo_ext;
                span_next = hi_ext - lo_ext + 32'd1;
            end
            madg_pkg::ST_DEF_ACC:
            begin
                c0_next = c0_reg - prod_reg;
                if (k_reg != '0)
                begin
                    coef_next = coef_reg * span_reg;
                    k_next    = k_reg - 1'b1;
                end
            end
            madg_pkg::ST_REF_MUL:
            begin
                prod_next = coef_rdata * idx_ext;
                hit_next  = cur_reg.id_ok && (pos_reg < desc_dims) &&
                            (int'(pos_reg) < madg_pkg::MAX_DIMS);
                offs_next = cur_reg.id_ok ? desc_rdata[31:0] : 32'd0;
            end
            madg_pkg::ST_REF_ACC:
            begin
                if (cur_reg.last)
                begin
                    // emit the address and close the reference
                    if (!out_busy)
                    begin
                        out_valid_next = 1'b1;
                        out_id_next    = cur_reg.id;
                        out_addr_next  = offs_reg + acc_sum;
                        acc_next       = 32'd0;
                        pos_next       = '0;
                    end
                end
                else
                begin
                    acc_next = acc_sum;
                    if (int'(pos_reg) < madg_pkg::MAX_DIMS)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= madg_pkg::ST_IDLE;
            pos_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload without reset
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        k_reg        <= k_next;
        coef_reg     <= coef_next;
        c0_reg       <= c0_next;
        prod_reg     <= prod_next;
        span_reg     <= span_next;
        offs_reg     <= offs_next;
        hit_reg      <= hit_next;
        out_id_reg   <= out_id_next;
        out_addr_reg <= out_addr_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.ref_array_id = out_id_reg;
    assign results.address      = out_addr_reg;

    `MADG_ASSERT_ALWAYS(a_pos_bound, int'(pos_reg) <= madg_pkg::MAX_DIMS)
    `MADG_ASSERT_NEXT(a_emit_sets_valid, out_load, out_valid_reg)
    `MADG_ASSERT_NEXT(a_emit_clears_acc, out_load, (acc_reg == 32'd0) && (pos_reg == '0))

endmodule
